// ===== rtl/ddbl_pkg.sv =====
// Shared constants, types and state encoding for the decimal text converter.
`timescale 1ns / 1ps
package ddbl_pkg;

   localparam int MAX_DIGITS   = 10;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 4;
   localparam int BCD_DIGITS   = 10;
   localparam int STEP_W       = $clog2(VALUE_W);
   localparam int IDX_W        = 4;
   localparam int REQ_DATA_W   = 40;
   localparam int CHAR_W       = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef logic [BCD_DIGITS-1:0][3:0] bcd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/ddbl_bcd_conv.sv =====
// Iterative shift-add-3 binary to BCD converter, one bit per cycle.
`timescale 1ns / 1ps
module ddbl_bcd_conv
   import ddbl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] value,
   output logic               done,
   output bcd_type            bcd
);

   logic [VALUE_W-1:0]      shreg_ff, shreg_in;
   bcd_type                 bcd_ff, bcd_in, adj;
   logic [BCD_DIGITS*4-1:0] adj_bits;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    run_ff, run_in;
   logic                    done_ff, done_in;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? 4'(bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
   end

   assign adj_bits = adj;

   always_comb begin
      shreg_in = shreg_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shreg_in = value;
         bcd_in   = '0;
         step_in  = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         bcd_in   = {adj_bits[BCD_DIGITS*4-2:0], shreg_ff[VALUE_W-1]};
         shreg_in = {shreg_ff[VALUE_W-2:0], 1'b0};
         step_in  = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(VALUE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shreg_ff <= shreg_in;
      bcd_ff   <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// ===== rtl/decimal_digits_blank_leading.sv =====
// Top level: binary number to blanked ASCII decimal text, one character per item.
//
// Input channel req_*: one item carries a 32-bit unsigned value and a 4-bit
// digit count. A count of 0 acts as 1, counts above 10 act as 10.
// Output channel rsp_*: one item per character, most significant first;
// rsp_tlast marks the final character. Leading zeros show as spaces, the
// final character is always a digit; higher digits than the count are dropped.
// The value passes through shift-add-3 in the BCD converter, then a handoff
// to emitting; the first character is offered once the converter is done,
// then one character per cycle while rsp_tready is high. The next item is
// accepted only after the final character of the previous one is taken.
// req_tready is high only while idle and out of reset; one item is in work
// at a time. A stall on rsp_tready holds the current character and its flag.
// Reset (synchronous, active high) returns the block to idle with no
// characters pending.
`timescale 1ns / 1ps
module decimal_digits_blank_leading
   import ddbl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // value[31:0], digit_count[35:32], zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CHAR_W-1:0]     rsp_tdata,   // character[7:0]
   output logic                  rsp_tlast    // last
);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               blank_ff, blank_in;
   logic               req_acc, rsp_acc;
   logic               conv_done;
   bcd_type            bcd;
   logic [COUNT_W-1:0] count;
   logic [IDX_W-1:0]   first_idx;
   logic [3:0]         digit;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign count   = req_tdata[VALUE_W +: COUNT_W];

   always_comb begin
      if (count == '0) begin
         first_idx = '0;
      end else if (count > COUNT_W'(MAX_DIGITS)) begin
         first_idx = IDX_W'(MAX_DIGITS - 1);
      end else begin
         first_idx = IDX_W'(count - 1'b1);
      end
   end

   ddbl_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (req_acc),
      .value (req_tdata[VALUE_W-1:0]),
      .done  (conv_done),
      .bcd   (bcd)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (conv_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_acc && idx_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = !reset;
         ST_CONV: req_tready = 1'b0;
         ST_EMIT: rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   assign digit     = bcd[idx_ff];
   assign rsp_tlast = (idx_ff == '0);
   assign rsp_tdata = (blank_ff && !rsp_tlast && digit == 4'd0) ?
                      CHAR_SPACE : (CHAR_ZERO | {4'd0, digit});

   always_comb begin
      idx_in   = idx_ff;
      blank_in = blank_ff;
      if (req_acc) begin
         idx_in   = first_idx;
         blank_in = 1'b1;
      end else if (rsp_acc) begin
         if (digit != 4'd0) blank_in = 1'b0;
         if (idx_ff != '0) idx_in = IDX_W'(idx_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         blank_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         blank_ff <= blank_in;
      end
   end

endmodule

// ===== tb/decimal_digits_blank_leading_tb.sv =====
// Testbench for the decimal text converter: directed and random numbers checked per character.
`timescale 1ns / 1ps
module decimal_digits_blank_leading_tb
   import ddbl_pkg::*;
();

   localparam int CLK_PERIOD  = 12;
   localparam int RESET_LEN   = 9;
   localparam int MAX_GAP     = 16;
   localparam int RANDOM_REQS = 330;
   localparam int SETTLE_LEN  = 60;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              is_final;
   } glyph_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // value[31:0], digit_count[35:32], zero
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [CHAR_W-1:0]     rsp_tdata;    // character[7:0]
   logic                  rsp_tlast;    // last

   glyph_type   pending_glyphs[$];
   int          error_count;
   int          chars_checked;
   int          reqs_sent;
   int          cycle_count;
   logic [15:0] counts_seen;
   bit          no_idle;

   decimal_digits_blank_leading uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic int pick_gap();
      if (no_idle || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Blanked decimal text of one request, most significant character first.
   function automatic void predict_text(input logic [VALUE_W-1:0] number,
                                        input logic [COUNT_W-1:0] count);
      logic [3:0]         digit[MAX_DIGITS];
      logic [VALUE_W-1:0] rest;
      int                 width;
      bit                 blanking;
      glyph_type          g;
      width = (count == 0) ? 1 : (count > MAX_DIGITS) ? MAX_DIGITS : int'(count);
      rest = number;
      for (int i = width - 1; i >= 0; i--) begin
         digit[i] = 4'(rest % 10);
         rest = rest / 10;
      end
      blanking = 1'b1;
      for (int i = 0; i < width; i++) begin
         g.is_final = (i == width - 1);
         if (blanking && !g.is_final && digit[i] == 0) begin
            g.code = CHAR_SPACE;
         end else begin
            blanking = 1'b0;
            g.code = CHAR_ZERO + CHAR_W'(digit[i]);
         end
         pending_glyphs.push_back(g);
      end
   endfunction

   // Holds req_tvalid high across back-to-back items; lowers it only for a gap.
   task automatic send_number(input logic [VALUE_W-1:0] number,
                              input logic [COUNT_W-1:0] count);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, count, number};
      do @(posedge clock); while (!req_tready);
      predict_text(number, count);
      reqs_sent++;
      counts_seen[count] = 1'b1;
   endtask

   task automatic wait_for_text();
      req_tvalid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
   endtask

   // Receiver: per-item stall before raising rsp_tready.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      glyph_type want;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_glyphs.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display("unexpected item: char %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_glyphs.pop_front();
            chars_checked++;
            if (rsp_tdata !== want.code || rsp_tlast !== want.is_final) begin
               error_count++;
               if (error_count <= SHOW_LIMIT)
                  $display("mismatch: expected char %h last %b, got char %h last %b",
                           want.code, want.is_final, rsp_tdata, rsp_tlast);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("decimal_digits_blank_leading regression: fail");
         $finish;
      end
   end

   task automatic test_count_edges();
      send_number(32'd7, 4'd0);
      send_number(32'd0, 4'd0);
      send_number(32'hFFFF_FFFF, 4'd1);
      send_number(32'hFFFF_FFFF, 4'd10);
      send_number(32'hFFFF_FFFF, 4'd11);
      send_number(32'd42, 4'd15);
      send_number(32'd5, 4'd10);
   endtask

   task automatic test_zero_blanking();
      send_number(32'd0, 4'd1);
      send_number(32'd0, 4'd5);
      send_number(32'd0, 4'd10);
      send_number(32'd1_000_000_000, 4'd10);
      send_number(32'd1_000_000_000, 4'd9);
      send_number(32'd100, 4'd2);
      send_number(32'd1_000_000_001, 4'd10);
   endtask

   task automatic test_truncation();
      send_number(32'd1_234_567_890, 4'd4);
      send_number(32'd4_294_967_295, 4'd9);
      send_number(32'd99_999, 4'd3);
      send_number(32'd1_000_000_000, 4'd1);
      wait_for_text();
   endtask

   function automatic logic [VALUE_W-1:0] shape_number();
      logic [63:0] acc;
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 9);
         1: return $urandom_range(0, 99_999);
         2: begin
            // decimal digits with many zeros inside
            acc = 0;
            for (int i = 0; i < MAX_DIGITS; i++)
               acc = acc * 10 + (($urandom_range(0, 1) == 1) ? $urandom_range(1, 9) : 0);
            return acc[VALUE_W-1:0];
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_numbers();
      logic [COUNT_W-1:0] count;
      for (int i = 0; i < RANDOM_REQS; i++) begin
         no_idle = ((i / 40) % 3 == 2);
         if ($urandom_range(0, 7) == 0)
            count = $urandom_range(0, 15);
         else
            count = $urandom_range(1, MAX_DIGITS);
         send_number(shape_number(), count);
         if (i == RANDOM_REQS / 2)
            wait_for_text();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      error_count  = 0;
      chars_checked = 0;
      reqs_sent    = 0;
      cycle_count  = 0;
      counts_seen  = '0;
      no_idle      = 1'b0;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      test_count_edges();
      test_zero_blanking();
      test_truncation();
      test_random_numbers();

      wait_for_text();
      repeat (SETTLE_LEN) @(posedge clock);

      $display("sent %0d numbers, checked %0d characters, digit counts seen %b",
               reqs_sent, chars_checked, counts_seen);
      $display("zero values, dropped high digits and inner zeros exercised under random stalls");
      if (error_count == 0 && pending_glyphs.size() == 0)
         $display("decimal_digits_blank_leading regression: pass");
      else
         $display("decimal_digits_blank_leading regression: fail");
      $finish;
   end

endmodule
